>>> src/udpfh_pkg.sv
`default_nettype none
package udpfh_pkg;

   // Default values of the top-level parameters.
   localparam int ADDR_LIMIT_MAX_DEF    = 1024;
   localparam int MAX_MESSAGE_BYTES_DEF = 65535;

   // Field widths.
   localparam int ALEN_W  = 11;
   localparam int COUNT_W = 16;

   // Reset value of the address limit register.
   localparam logic [ALEN_W-1:0] ADDR_LIMIT_RESET = 11'd255;

   // Fixed header length and the value mask of the first varint byte.
   localparam logic [ALEN_W-1:0] HDR_BYTES   = 11'd8;
   localparam logic [7:0]        VARINT_MASK = 8'h3F;

   // Parse phases.
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_VFIRST  = 3'd1;
   localparam logic [2:0] PH_VREST   = 3'd2;
   localparam logic [2:0] PH_ADDR    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_ERROR   = 3'd5;

   // Message status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_TRUNC = 2'd1;
   localparam logic [1:0] ST_FRAG  = 2'd2;
   localparam logic [1:0] ST_LONG  = 2'd3;

   // Byte class codes.
   localparam logic [1:0] CLS_HEADER  = 2'd0;
   localparam logic [1:0] CLS_ADDRESS = 2'd1;
   localparam logic [1:0] CLS_PAYLOAD = 2'd2;
   localparam logic [1:0] CLS_IGNORED = 2'd3;

   // One result item.
   typedef struct packed {
      logic [1:0]         byte_class;
      logic [7:0]         byte_echo;
      logic               done_res;
      logic [1:0]         status;
      logic [31:0]        session_tag;
      logic [15:0]        packet_tag;
      logic [7:0]         frag_id;
      logic [7:0]         frag_total;
      logic [ALEN_W-1:0]  address_length;
      logic [ALEN_W-1:0]  payload_start;
      logic [COUNT_W-1:0] data_length;
   } result_type;

endpackage
`default_nettype wire

>>> src/udpfh_if.sv
`default_nettype none
// Request channel: one message byte per item.
interface udpfh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       is_last;

   modport source (output valid, output byte_in, output is_last, input ready);
   modport sink (input valid, input byte_in, input is_last, output ready);
endinterface

// Response channel: one classified byte, with the summary on the last one.
interface udpfh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  byte_class;
   logic [7:0]  byte_echo;
   logic        done_res;
   logic [1:0]  status;
   logic [31:0] session_tag;
   logic [15:0] packet_tag;
   logic [7:0]  frag_id;
   logic [7:0]  frag_total;
   logic [10:0] address_length;
   logic [10:0] payload_start;
   logic [15:0] data_length;

   modport source (output valid, output byte_class, output byte_echo, output done_res,
                   output status, output session_tag, output packet_tag, output frag_id,
                   output frag_total, output address_length, output payload_start,
                   output data_length, input ready);
   modport sink (input valid, input byte_class, input byte_echo, input done_res,
                 input status, input session_tag, input packet_tag, input frag_id,
                 input frag_total, input address_length, input payload_start,
                 input data_length, output ready);
endinterface
`default_nettype wire

>>> src/udpfh_step.sv
`default_nettype none
module udpfh_step
   import udpfh_pkg::*;
#(
   parameter int ADDR_LIMIT_MAX    = ADDR_LIMIT_MAX_DEF,
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        byte_in,
   input  wire logic              is_last,
   input  wire logic [ALEN_W-1:0] addr_limit,
   output result_type            result
);

   // Ceilings that follow from the parameters.
   localparam logic [ALEN_W-1:0] LimCap =
      (ADDR_LIMIT_MAX < 2047) ? ALEN_W'(ADDR_LIMIT_MAX) : {ALEN_W{1'b1}};
   localparam logic [COUNT_W-1:0] PayCap =
      (MAX_MESSAGE_BYTES < 65535) ? COUNT_W'(MAX_MESSAGE_BYTES) : {COUNT_W{1'b1}};

   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         hpos_ff, hpos_in;
   logic [2:0]         vrem_ff, vrem_in;
   logic [ALEN_W-1:0]  acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic [ALEN_W-1:0]  arem_ff, arem_in;
   logic [31:0]        sess_ff, sess_in;
   logic [15:0]        pkt_ff, pkt_in;
   logic [7:0]         fidx_ff, fidx_in;
   logic [7:0]         ftot_ff, ftot_in;
   logic [1:0]         err_ff, err_in;
   logic [ALEN_W-1:0]  poff_ff, poff_in;
   logic [COUNT_W-1:0] pcnt_ff, pcnt_in;

   logic [ALEN_W-1:0]  lim;
   logic [1:0]         cls;
   logic               do_finish;
   logic [3:0]         nbytes;
   logic [18:0]        shifted;
   logic [1:0]         st;

   // The limit in force is the smaller of the register and the ceiling.
   assign lim = (addr_limit < LimCap) ? addr_limit : LimCap;

   // Next state for the byte being processed.
   always_comb begin
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      vrem_in   = vrem_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      arem_in   = arem_ff;
      sess_in   = sess_ff;
      pkt_in    = pkt_ff;
      fidx_in   = fidx_ff;
      ftot_in   = ftot_ff;
      err_in    = err_ff;
      poff_in   = poff_ff;
      pcnt_in   = pcnt_ff;
      cls       = CLS_HEADER;
      do_finish = 1'b0;
      nbytes    = 4'd1 << byte_in[7:6];
      shifted   = {acc_ff, byte_in};

      unique case (phase_ff)
         PH_HEADER: begin
            if (hpos_ff < 4'd4) begin
               sess_in = {sess_ff[23:0], byte_in};
            end else if (hpos_ff < 4'd6) begin
               pkt_in = {pkt_ff[7:0], byte_in};
            end else if (hpos_ff == 4'd6) begin
               fidx_in = byte_in;
            end else begin
               ftot_in = byte_in;
            end
            if (hpos_ff >= 4'd7) begin
               // The count has just arrived; check it against the index.
               if (ftot_in == 8'd0 || fidx_ff >= ftot_in) begin
                  err_in   = ST_FRAG;
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_VFIRST;
               end
            end else begin
               hpos_in = hpos_ff + 4'd1;
            end
         end
         PH_VFIRST: begin
            acc_in  = ALEN_W'(byte_in & VARINT_MASK);
            ovf_in  = 1'b0;
            vrem_in = 3'(nbytes - 4'd1);
            poff_in = HDR_BYTES + ALEN_W'(nbytes);
            if (vrem_in == 3'd0) begin
               do_finish = 1'b1;
            end else begin
               phase_in = PH_VREST;
            end
         end
         PH_VREST: begin
            ovf_in  = ovf_ff | (shifted[18:ALEN_W] != '0);
            acc_in  = shifted[ALEN_W-1:0];
            vrem_in = vrem_ff - 3'd1;
            do_finish = (vrem_in == 3'd0);
         end
         PH_ADDR: begin
            cls     = CLS_ADDRESS;
            arem_in = arem_ff - ALEN_W'(1);
            if (arem_in == '0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            cls = CLS_PAYLOAD;
            if (pcnt_ff < PayCap) begin
               pcnt_in = pcnt_ff + COUNT_W'(1);
            end
         end
         default: begin
            cls = CLS_IGNORED;
         end
      endcase

      // Varint complete: check the length and place the payload.
      if (do_finish) begin
         if (ovf_in || acc_in > lim) begin
            err_in   = ST_LONG;
            phase_in = PH_ERROR;
         end else begin
            arem_in  = acc_in;
            poff_in  = poff_in + acc_in;
            phase_in = (acc_in == '0) ? PH_PAYLOAD : PH_ADDR;
         end
      end
   end

   // Result item, with the summary on the last byte only.
   always_comb begin
      st = err_in;
      if (st == ST_OK && phase_in != PH_PAYLOAD) begin
         st = ST_TRUNC;
      end
      result = '0;
      result.byte_class = cls;
      result.byte_echo  = byte_in;
      if (is_last) begin
         result.done_res    = 1'b1;
         result.status      = st;
         result.session_tag = sess_in;
         result.packet_tag  = pkt_in;
         result.frag_id     = fidx_in;
         result.frag_total  = ftot_in;
         if (st == ST_OK) begin
            result.address_length = acc_in;
            result.payload_start  = poff_in;
            result.data_length    = pcnt_in;
         end
      end
   end

   // Parser state; the last byte of a message returns it to reset.
   always_ff @(posedge clock) begin
      if (reset || (step_en && is_last)) begin
         phase_ff <= PH_HEADER;
         hpos_ff  <= '0;
         vrem_ff  <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         arem_ff  <= '0;
         sess_ff  <= '0;
         pkt_ff   <= '0;
         fidx_ff  <= '0;
         ftot_ff  <= '0;
         err_ff   <= ST_OK;
         poff_ff  <= '0;
         pcnt_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         hpos_ff  <= hpos_in;
         vrem_ff  <= vrem_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         arem_ff  <= arem_in;
         sess_ff  <= sess_in;
         pkt_ff   <= pkt_in;
         fidx_ff  <= fidx_in;
         ftot_ff  <= ftot_in;
         err_ff   <= err_in;
         poff_ff  <= poff_in;
         pcnt_ff  <= pcnt_in;
      end
   end

endmodule
`default_nettype wire

>>> src/udp_fragment_header_parser_unit.sv
// An accepted request item passes through the input register, then the response register.
// Throughput: one byte per cycle while responses are taken; the input register and the
// response register each hold an item, so a byte is still taken while a response waits.
// Reset (synchronous, active high) returns the parser to the start of a
// message, empties both registers and sets the address limit to 255.
`default_nettype none
module udp_fragment_header_parser_unit
   import udpfh_pkg::*;
#(
   parameter int ADDR_LIMIT_MAX    = ADDR_LIMIT_MAX_DEF,
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   udpfh_req_if.sink              req_chan,
   udpfh_rsp_if.source            rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [ALEN_W-1:0] csr_wr_data
);

   logic [ALEN_W-1:0] addr_limit_ff;
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;
   result_type        step_result;
   logic              move;

   // Address limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_limit_ff <= ADDR_LIMIT_RESET;
      end else if (csr_wr_en) begin
         addr_limit_ff <= csr_wr_data;
      end
   end

   // An item moves to the response register when that register is free or draining.
   assign move           = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || move;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.byte_in;
         in_last_ff <= req_chan.is_last;
      end
   end

   // Parser state and per-byte logic.
   udpfh_step #(
      .ADDR_LIMIT_MAX    (ADDR_LIMIT_MAX),
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .step_en    (move),
      .byte_in    (in_byte_ff),
      .is_last    (in_last_ff),
      .addr_limit (addr_limit_ff),
      .result     (step_result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.byte_class     = rsp_data_ff.byte_class;
   assign rsp_chan.byte_echo      = rsp_data_ff.byte_echo;
   assign rsp_chan.done_res       = rsp_data_ff.done_res;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.session_tag    = rsp_data_ff.session_tag;
   assign rsp_chan.packet_tag     = rsp_data_ff.packet_tag;
   assign rsp_chan.frag_id        = rsp_data_ff.frag_id;
   assign rsp_chan.frag_total     = rsp_data_ff.frag_total;
   assign rsp_chan.address_length = rsp_data_ff.address_length;
   assign rsp_chan.payload_start  = rsp_data_ff.payload_start;
   assign rsp_chan.data_length    = rsp_data_ff.data_length;

`ifndef SYNTH
   // A byte that is not the last one carries no summary.
   a_no_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.done_res |->
         rsp_data_ff.status == ST_OK && rsp_data_ff.session_tag == '0 &&
         rsp_data_ff.data_length == '0)
      else $error("summary fields set on a byte that is not the last");

   // A failed message reports no lengths or offset.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.address_length == '0 && rsp_data_ff.payload_start == '0 &&
         rsp_data_ff.data_length == '0)
      else $error("lengths reported for a failed message");

   // A held input item stays in the input register until it moves on.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held input item lost or changed");
`endif

endmodule
`default_nettype wire

>>> tb/tb_udp_fragment_header_parser_unit.sv
`default_nettype none
module tb_udp_fragment_header_parser_unit
   import udpfh_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD         = 4;
   localparam int IDLE_PERCENT       = 13;
   localparam int RANDOM_ITEMS       = 1400;
   localparam int PHASES             = 6;
   localparam int QUIET_PHASE        = 3;
   localparam int REPORT_LIMIT       = 10;
   localparam int HOLD_AT_RESULT     = 800;
   localparam int HOLD_CYCLES        = 400;
   localparam logic [COUNT_W-1:0] PAY_COUNT_CAP =
      (MAX_MESSAGE_BYTES_DEF < 65535) ? COUNT_W'(MAX_MESSAGE_BYTES_DEF) : '1;

   typedef enum logic [2:0] {
      MSG_GOOD,
      MSG_TRUNC,
      MSG_BAD_FRAG,
      MSG_TOO_LONG,
      MSG_NOISE
   } msg_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [ALEN_W-1:0] csr_wr_data;

   udpfh_req_if req_bus ();
   udpfh_rsp_if rsp_bus ();

   udp_fragment_header_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Bytes waiting to be offered, results still owed, and the message under construction.
   stream_byte_type outbound[$];
   result_type      expected_results[$];
   logic [7:0]      frame[$];

   int failures     = 0;
   int results_seen = 0;
   int random_items = 0;
   bit quiet        = 1'b0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   // Parser state mirrored by the predictor.
   logic [ALEN_W-1:0]  addr_limit;
   logic [2:0]         msg_phase;
   logic [3:0]         hdr_pos;
   logic [2:0]         varint_left;
   logic [ALEN_W-1:0]  alen_acc;
   logic               alen_over;
   logic [ALEN_W-1:0]  addr_left;
   logic [31:0]        sess_id_r;
   logic [15:0]        pkt_id_r;
   logic [7:0]         frag_idx_r;
   logic [7:0]         frag_tot_r;
   logic [1:0]         msg_status;
   logic [ALEN_W-1:0]  pay_offset;
   logic [COUNT_W-1:0] pay_count;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Return the parser to the start of a message.
   function automatic void clear_parser();
      msg_phase   = PH_HEADER;
      hdr_pos     = '0;
      varint_left = '0;
      alen_acc    = '0;
      alen_over   = 1'b0;
      addr_left   = '0;
      sess_id_r   = '0;
      pkt_id_r    = '0;
      frag_idx_r  = '0;
      frag_tot_r  = '0;
      msg_status  = ST_OK;
      pay_offset  = '0;
      pay_count   = '0;
   endfunction

   // The address length is complete: check it against the limit in force.
   function automatic void close_varint();
      logic [ALEN_W-1:0] lim;
      lim = addr_limit;
      if (lim > ADDR_LIMIT_MAX_DEF) lim = ALEN_W'(ADDR_LIMIT_MAX_DEF);
      if (alen_over || alen_acc > lim) begin
         msg_status = ST_LONG;
         msg_phase  = PH_ERROR;
      end else begin
         addr_left  = alen_acc;
         pay_offset = pay_offset + alen_acc;
         msg_phase  = (alen_acc == 0) ? PH_PAYLOAD : PH_ADDR;
      end
   endfunction

   // Advance the mirrored parser by one byte and return the result item it owes.
   function automatic result_type parse_byte(input logic [7:0] b, input logic last);
      result_type          r;
      logic [1:0]          cls;
      logic [3:0]          nbytes;
      logic [ALEN_W+7:0]   shifted;
      logic [1:0]          st;
      cls = CLS_HEADER;
      case (msg_phase)
         PH_HEADER: begin
            if (hdr_pos < 4) sess_id_r = {sess_id_r[23:0], b};
            else if (hdr_pos < 6) pkt_id_r = {pkt_id_r[7:0], b};
            else if (hdr_pos == 6) frag_idx_r = b;
            else frag_tot_r = b;
            if (hdr_pos >= 7) begin
               if (frag_tot_r == 0 || frag_idx_r >= frag_tot_r) begin
                  msg_status = ST_FRAG;
                  msg_phase  = PH_ERROR;
               end else begin
                  msg_phase = PH_VFIRST;
               end
            end else begin
               hdr_pos = hdr_pos + 4'd1;
            end
         end
         PH_VFIRST: begin
            nbytes      = 4'd1 << b[7:6];
            alen_acc    = ALEN_W'(b & VARINT_MASK);
            alen_over   = 1'b0;
            varint_left = 3'(nbytes - 4'd1);
            pay_offset  = HDR_BYTES + ALEN_W'(nbytes);
            if (varint_left == 0) close_varint();
            else msg_phase = PH_VREST;
         end
         PH_VREST: begin
            shifted = {alen_acc, b};
            if (shifted[ALEN_W+7:ALEN_W] != '0) alen_over = 1'b1;
            alen_acc    = shifted[ALEN_W-1:0];
            varint_left = varint_left - 3'd1;
            if (varint_left == 0) close_varint();
         end
         PH_ADDR: begin
            cls       = CLS_ADDRESS;
            addr_left = addr_left - ALEN_W'(1);
            if (addr_left == 0) msg_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            cls = CLS_PAYLOAD;
            if (pay_count < PAY_COUNT_CAP) pay_count = pay_count + COUNT_W'(1);
         end
         default: begin
            cls = CLS_IGNORED;
         end
      endcase
      r            = '0;
      r.byte_class = cls;
      r.byte_echo  = b;
      if (last) begin
         st = msg_status;
         if (st == ST_OK && msg_phase != PH_PAYLOAD) st = ST_TRUNC;
         r.done_res    = 1'b1;
         r.status      = st;
         r.session_tag = sess_id_r;
         r.packet_tag  = pkt_id_r;
         r.frag_id     = frag_idx_r;
         r.frag_total  = frag_tot_r;
         if (st == ST_OK) begin
            r.address_length = alen_acc;
            r.payload_start  = pay_offset;
            r.data_length    = pay_count;
         end
         clear_parser();
      end
      return r;
   endfunction

   function automatic string show_result(input result_type r);
      return $sformatf({"class %0d byte %h done %b status %0d session %h packet %h ",
                        "frag %0d/%0d alen %0d offset %0d dlen %0d"},
                       r.byte_class, r.byte_echo, r.done_res, r.status, r.session_tag,
                       r.packet_tag, r.frag_id, r.frag_total, r.address_length,
                       r.payload_start, r.data_length);
   endfunction

   task automatic build_header(input logic [31:0] sess, input logic [15:0] pkt,
                               input logic [7:0] fid, input logic [7:0] fcnt);
      frame.push_back(sess[31:24]);
      frame.push_back(sess[23:16]);
      frame.push_back(sess[15:8]);
      frame.push_back(sess[7:0]);
      frame.push_back(pkt[15:8]);
      frame.push_back(pkt[7:0]);
      frame.push_back(fid);
      frame.push_back(fcnt);
   endtask

   // Encode a variable-length integer, usually in its shortest form, sometimes longer.
   task automatic build_varint(input logic [63:0] value);
      int         code;
      int         i;
      logic [7:0] b;
      if (value < 64) code = 0;
      else if (value < 16384) code = 1;
      else if (value < 64'h4000_0000) code = 2;
      else code = 3;
      if ($urandom_range(3) == 0) code = $urandom_range(code, 3);
      for (i = (1 << code) - 1; i >= 0; i--) begin
         b = value[8*i +: 8];
         if (i == (1 << code) - 1) b[7:6] = code[1:0];
         frame.push_back(b);
      end
   endtask

   // Queue the message under construction, marking its final byte.
   task automatic send_frame();
      int              i;
      stream_byte_type sb;
      for (i = 0; i < frame.size(); i++) begin
         sb.data = frame[i];
         sb.last = (i == frame.size() - 1);
         outbound.push_back(sb);
      end
   endtask

   // Build one random message of the given kind and queue it.
   task automatic add_message(input msg_kind_type kind, input int pay_len);
      logic [7:0]        fcnt;
      logic [7:0]        fid;
      logic [63:0]       alen;
      logic [ALEN_W-1:0] cap;
      int                keep;
      frame.delete();
      if (kind == MSG_NOISE) begin
         repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
         random_items += frame.size();
      end else begin
         fcnt = 8'($urandom_range(1, 255));
         fid  = 8'($urandom_range(0, fcnt - 1));
         if (kind == MSG_BAD_FRAG) begin
            if ($urandom_range(1) == 0) begin
               fcnt = 8'd0;
               fid  = 8'($urandom);
            end else begin
               fid = 8'($urandom_range(fcnt, 255));
            end
         end
         build_header($urandom, 16'($urandom), fid, fcnt);
         if (kind != MSG_BAD_FRAG) begin
            cap = (addr_limit < ALEN_W'(16)) ? addr_limit : ALEN_W'(16);
            if (kind == MSG_TOO_LONG) begin
               if (addr_limit < 2047 && $urandom_range(1) == 0)
                  alen = 64'($urandom_range(addr_limit + 1, 2047));
               else
                  alen = {2'b00, 30'($urandom), 32'($urandom)} | 64'h800;
            end else if ($urandom_range(99) < 3) begin
               alen = 64'(addr_limit);
            end else begin
               alen = 64'($urandom_range(0, cap));
            end
            build_varint(alen);
            if (kind != MSG_TOO_LONG) begin
               repeat (alen) frame.push_back(8'($urandom));
               if (kind == MSG_GOOD) repeat (pay_len) frame.push_back(8'($urandom));
            end
         end
         // A truncated message stops before its address is complete.
         if (kind == MSG_TRUNC) begin
            keep = $urandom_range(1, frame.size() - 1);
            while (frame.size() > keep) void'(frame.pop_back());
         end
         random_items += frame.size();
         // Bytes after an error are ignored by the parser.
         if (kind == MSG_BAD_FRAG || kind == MSG_TOO_LONG)
            repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
      end
      send_frame();
   endtask

   // Wait until every queued item has been taken and every result has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (outbound.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Offer queued items; predict the result of each accepted one.
   always @(posedge clock) begin : drive_requests
      stream_byte_type sb;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.byte_in <= '0;
         req_bus.is_last <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(parse_byte(req_bus.byte_in, req_bus.is_last));
         if (!req_bus.valid || req_bus.ready) begin
            if (outbound.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
               sb = outbound.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.byte_in <= sb.data;
               req_bus.is_last <= sb.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Count out the one long hold-off of the receiver once enough results have arrived.
   always @(posedge clock) begin : hold_receiver
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
         end
      end
   end

   // Take result items and check them in order.
   always @(posedge clock) begin : collect_results
      result_type got;
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.byte_class, rsp_bus.byte_echo, rsp_bus.done_res, rsp_bus.status,
                   rsp_bus.session_tag, rsp_bus.packet_tag, rsp_bus.frag_id,
                   rsp_bus.frag_total, rsp_bus.address_length, rsp_bus.payload_start,
                   rsp_bus.data_length};
            results_seen++;
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("Result %0d arrived with none outstanding: %s",
                           results_seen, show_result(got));
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("Mismatch on result %0d", results_seen);
                     $display("  expected %s", show_result(want));
                     $display("  actual   %s", show_result(got));
                  end
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet || $urandom_range(99) >= IDLE_PERCENT;
         end
      end
   end

   // Directed messages, then random phases under several address limits.
   initial begin
      int                phase;
      int                pick;
      msg_kind_type      kind;
      logic [ALEN_W-1:0] new_limit;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      addr_limit = ADDR_LIMIT_RESET;
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A lone byte, a header with all-ones tags and an empty address, a zero fragment count
      // on the final byte, and an address length over the reset limit.
      frame.delete();
      frame.push_back(8'hA5);
      send_frame();
      frame.delete();
      build_header(32'hFFFF_FFFF, 16'hFFFF, 8'hFE, 8'hFF);
      frame.push_back(8'h00);
      send_frame();
      frame.delete();
      build_header('0, '0, 8'h00, 8'h00);
      send_frame();
      frame.delete();
      build_header(32'h0123_4567, 16'h89AB, 8'h00, 8'h01);
      build_varint(64'd1024);
      send_frame();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            wait_idle();
            case (phase)
               1: new_limit = '0;
               2: new_limit = ALEN_W'(ADDR_LIMIT_MAX_DEF);
               4: new_limit = ALEN_W'(1);
               default: new_limit = ALEN_W'($urandom_range(0, ADDR_LIMIT_MAX_DEF));
            endcase
            @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= new_limit;
            @(posedge clock);
            csr_wr_en <= 1'b0;
            addr_limit = new_limit;
            @(negedge clock);
         end
         quiet = (phase == QUIET_PHASE);

         while (random_items < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(99);
            if (pick < 60) kind = MSG_GOOD;
            else if (pick < 72) kind = MSG_TRUNC;
            else if (pick < 82) kind = MSG_BAD_FRAG;
            else if (pick < 92) kind = MSG_TOO_LONG;
            else kind = MSG_NOISE;
            add_message(kind, $urandom_range(0, 12));
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

>>> udp_fragment_header_parser_unit.f
src/udpfh_pkg.sv
src/udpfh_if.sv
src/udpfh_step.sv
src/udp_fragment_header_parser_unit.sv
tb/tb_udp_fragment_header_parser_unit.sv
